@@ hdl/apfm_pkg.sv @@
// Shared constants, types and the quarter-wave sine table for the ASK/PSK/FSK modulator.
package apfm_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int QTR_BITS  = TABLE_ADDR_BITS - 2;
  localparam int QTR_SIZE  = 1 << QTR_BITS;
  localparam int AMP_BITS  = 16;
  localparam int AMP_FRAC  = 15;
  localparam int CFG_BITS  = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int PROD_BITS = SAMPLE_BITS + AMP_BITS + 1;

  localparam int S_TDATA_BITS = 8;
  localparam int M_TDATA_BITS = ((3 * SAMPLE_BITS + 7) / 8) * 8;

  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint FULL_SCALE = SAMPLE_MAX;
  localparam longint ROUND_HALF = longint'(1) << (AMP_FRAC - 1);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // reset values of the registers
  localparam logic [CFG_BITS-1:0] CARRIER_STEP_RST   = 32'd53687091;
  localparam logic [CFG_BITS-1:0] TONE_ZERO_STEP_RST = 32'd80530637;
  localparam logic [CFG_BITS-1:0] TONE_ONE_STEP_RST  = 32'd107374182;
  localparam logic [AMP_BITS-1:0] AMP_ZERO_RST       = 16'd16384;
  localparam logic [AMP_BITS-1:0] AMP_ONE_RST        = 16'd32768;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CARRIER_STEP   = 3'd0,
    REG_TONE_ZERO_STEP = 3'd1,
    REG_TONE_ONE_STEP  = 3'd2,
    REG_AMP_ZERO       = 3'd3,
    REG_AMP_ONE        = 3'd4
  } cfg_reg_t;

  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AMP_BITS-1:0]           amp_t;
  typedef sample_t                       qtab_t [QTR_SIZE];

  // Quarter-wave value for step r of QTR_SIZE, Taylor series in Q30.
  function automatic logic [63:0] quarter_value(input logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (r * HALF_PI_Q30) >> QTR_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return (64'(sum) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int r = 0; r < QTR_SIZE; r++) begin
      t[r] = SAMPLE_BITS'(quarter_value(64'(r)));
    end
    return t;
  endfunction

  localparam qtab_t   QTAB = build_qtab();
  // value at the quarter-wave peak, one past the end of QTAB
  localparam sample_t QTOP = SAMPLE_BITS'(quarter_value(64'(QTR_SIZE)));

endpackage

@@ hdl/ask_psk_fsk_modulator_top.sv @@
// Binary ASK / PSK / FSK modulator: phase accumulators, sine lookup, keying, output register.
//
// Usage:
//  - Slave stream (s_*): one beat per sample tick, s_tdata[0] is the data bit
//    in force for that tick. Upper bits of s_tdata are ignored.
//  - Master stream (m_*): one beat per tick, m_tdata holds ask_sample [15:0],
//    psk_sample [31:16] and fsk_sample [47:32], all signed Q1.15.
//  - Config port: cfg_we with cfg_index/cfg_data writes a register
//    (0 carrier step, 1 FSK zero tone step, 2 FSK one tone step,
//    3 ASK gain for zero, 4 ASK gain for one). Other indexes are dropped.
//    Write only while the block is empty.
//  - Pipeline: an accepted input beat passes stage one, then stage two.
//    Stage one reads the sine table at the phases held before the tick;
//    stage two does the gain multiply, rounding, saturation and PSK flip.
//  - Throughput: one beat per clock while m_tready is high; the two pipeline
//    stages and the single add per accumulator set that figure.
//  - Reset (rst, synchronous): phases go to zero, registers to their
//    defaults, the pipeline empties. First tick afterwards gives sin(0).
//  - Stall: when m_tready is low the held beat stays put, the pipeline
//    fills, and s_tready drops once both stages are full.
module ask_psk_fsk_modulator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [apfm_pkg::S_TDATA_BITS-1:0]    s_tdata,   // [0] data_bit
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [apfm_pkg::M_TDATA_BITS-1:0]    m_tdata,   // ask_sample, psk_sample, fsk_sample
  input  logic                                 cfg_we,
  input  logic [apfm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [apfm_pkg::CFG_BITS-1:0]        cfg_data
);
  import apfm_pkg::*;

  // config registers
  phase_t carrier_step;
  phase_t tone_zero_step;
  phase_t tone_one_step;
  amp_t   amplitude_zero;
  amp_t   amplitude_one;

  // phase accumulators
  phase_t carrier_phase;
  phase_t tone_zero_phase;
  phase_t tone_one_phase;

  // stage one
  logic    s1_valid;
  logic    s1_bit;
  sample_t s1_carrier;
  sample_t s1_fsk;
  amp_t    s1_amp;

  // stage two (output)
  sample_t ask_out;
  sample_t psk_out;
  sample_t fsk_out;

  logic    in_beat;
  logic    advance;
  logic    data_bit;
  sample_t carrier_smp;
  sample_t tone_zero_smp;
  sample_t tone_one_smp;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] rounded;
  logic signed [PROD_BITS-1:0] scaled;
  sample_t                     ask_sat;

  // Sine lookup from quarter-wave table using top address bits of the phase.
  function automatic sample_t sine_lookup(input phase_t ph);
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [QTR_BITS-1:0]        r;
    logic [QTR_BITS-1:0]        r_mirror;
    sample_t                    mag;
    addr     = ph[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    r        = addr[QTR_BITS-1:0];
    r_mirror = ~r + {{(QTR_BITS-1){1'b0}}, 1'b1};
    if (addr[TABLE_ADDR_BITS-2]) begin
      // descending quarter; r of zero sits on the peak
      mag = (r == '0) ? QTOP : QTAB[r_mirror];
    end else begin
      mag = QTAB[r];
    end
    return addr[TABLE_ADDR_BITS-1] ? -mag : mag;
  endfunction

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign in_beat  = s_tvalid && s_tready;
  assign data_bit = s_tdata[0];

  always_comb begin
    carrier_smp   = sine_lookup(carrier_phase);
    tone_zero_smp = sine_lookup(tone_zero_phase);
    tone_one_smp  = sine_lookup(tone_one_phase);
  end

  // gain: round half up at Q15, then saturate
  always_comb begin
    prod    = $signed(s1_carrier) * $signed({1'b0, s1_amp});
    rounded = prod + PROD_BITS'(ROUND_HALF);
    scaled  = rounded >>> AMP_FRAC;
    if (scaled > $signed(PROD_BITS'(SAMPLE_MAX))) begin
      ask_sat = SAMPLE_BITS'(SAMPLE_MAX);
    end else if (scaled < $signed(PROD_BITS'(SAMPLE_MIN))) begin
      ask_sat = SAMPLE_BITS'(SAMPLE_MIN);
    end else begin
      ask_sat = scaled[SAMPLE_BITS-1:0];
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step   <= PHASE_BITS'(CARRIER_STEP_RST);
      tone_zero_step <= PHASE_BITS'(TONE_ZERO_STEP_RST);
      tone_one_step  <= PHASE_BITS'(TONE_ONE_STEP_RST);
      amplitude_zero <= AMP_ZERO_RST;
      amplitude_one  <= AMP_ONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CARRIER_STEP:   carrier_step   <= PHASE_BITS'(cfg_data);
        REG_TONE_ZERO_STEP: tone_zero_step <= PHASE_BITS'(cfg_data);
        REG_TONE_ONE_STEP:  tone_one_step  <= PHASE_BITS'(cfg_data);
        REG_AMP_ZERO:       amplitude_zero <= cfg_data[AMP_BITS-1:0];
        REG_AMP_ONE:        amplitude_one  <= cfg_data[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // accumulators step once per accepted beat, whatever the bit
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_phase   <= '0;
      tone_zero_phase <= '0;
      tone_one_phase  <= '0;
    end else if (in_beat) begin
      carrier_phase   <= carrier_phase + carrier_step;
      tone_zero_phase <= tone_zero_phase + tone_zero_step;
      tone_one_phase  <= tone_one_phase + tone_one_step;
    end
  end

  // stage one: table outputs and keyed selections
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_bit     <= data_bit;
      s1_carrier <= carrier_smp;
      s1_fsk     <= data_bit ? tone_one_smp : tone_zero_smp;
      s1_amp     <= data_bit ? amplitude_one : amplitude_zero;
    end
  end

  // stage two: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      ask_out <= ask_sat;
      psk_out <= s1_bit ? -s1_carrier : s1_carrier;  // table stays within +-full scale
      fsk_out <= s1_fsk;
    end
  end

  assign m_tdata = M_TDATA_BITS'({fsk_out, psk_out, ask_out});

  // accumulator steps exactly on accepted beats
  a_phase_step : assert property (@(posedge clk) disable iff (rst)
    (!rst && in_beat) |=> carrier_phase == $past(carrier_phase + carrier_step))
    else $error("carrier phase did not step on accepted beat");

  a_phase_hold : assert property (@(posedge clk) disable iff (rst)
    (!rst && !in_beat) |=> $stable(tone_one_phase) && $stable(tone_zero_phase))
    else $error("tone phase moved without an accepted beat");

  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s1_valid))
    else $error("output beat appeared with empty stage one");

  a_psk_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> psk_out != SAMPLE_BITS'(SAMPLE_MIN))
    else $error("psk sample outside table range");

endmodule
